// ----- rtl/priority_wait_queue_class_removal_unit_assert.svh -----
// Assertion macros shared by the priority wait queue RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef PRIORITY_WAIT_QUEUE_CLASS_REMOVAL_UNIT_ASSERT_SVH
`define PRIORITY_WAIT_QUEUE_CLASS_REMOVAL_UNIT_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define PWQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the following cycle.
`define PWQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/pwq_pkg.sv -----
// Package for the priority wait queue: sizes, entry type, command and match codes.
// No dependencies; used by pwq_match and the top-level queue unit.
package pwq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int NAME_W   = 64;
    localparam int PRIO_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [PRIO_W-1:0] CLASS_LOW   = 4'd1;
    localparam logic [PRIO_W-1:0] CLASS_OTHER = 4'd2;

    localparam logic [1:0] MATCH_GE      = 2'd0;
    localparam logic [1:0] MATCH_LOW     = 2'd1;
    localparam logic [1:0] MATCH_NOT_ONE = 2'd2;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [PRIO_W-1:0] key;
        logic [PRIO_W-1:0] prio;
    } match_req_t;

endpackage

// ----- rtl/pwq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the queue entries for the priority wait queue.
module pwq_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pwq_match.sv -----
// Shared priority compare unit used by the insert walk and the class scan.
// Depends on pwq_pkg for the match codes and the request struct.
module pwq_match (
    input  pwq_pkg::match_req_t req,
    output logic                hit
);
    import pwq_pkg::*;

    always_comb
    begin
        case (req.mode)
            MATCH_GE:      hit = (req.prio >= req.key);
            MATCH_LOW:     hit = (req.prio <= CLASS_LOW);
            MATCH_NOT_ONE: hit = (req.prio != CLASS_LOW);
            default:       hit = 1'b0;
        endcase
    end

endmodule

// ----- rtl/priority_wait_queue_class_removal_unit.sv -----
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+-------------------------------------------
//  in      | into      | in_valid / in_stall | cmd, name_code, priority_req
//  out     | out of    | out_valid/out_stall | ok, removed_name, removed_priority,
//          |           |                     | head_name, head_priority, is_empty, entry_count
//
// An insert walks down from the tail in ST_INS; a remove scans in ST_SCAN and shifts up in
// ST_SHIFT; rejected beats skip to ST_HEAD, where all read the head for ST_FIN to load.
// With the single RAM read port, one entry is read and one moved per cycle. in_stall is
// high from acceptance until the result is loaded. Reset clears the count and control, not
// the RAM. A held result register lets the next beat enter while the result waits.
// Depends on pwq_pkg, pwq_ram, pwq_match and the assertion header.
module priority_wait_queue_class_removal_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       cmd,
    input  logic [pwq_pkg::NAME_W-1:0] name_code,
    input  logic [pwq_pkg::PRIO_W-1:0] priority_req,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       ok,
    output logic [pwq_pkg::NAME_W-1:0] removed_name,
    output logic [pwq_pkg::PRIO_W-1:0] removed_priority,
    output logic [pwq_pkg::NAME_W-1:0] head_name,
    output logic [pwq_pkg::PRIO_W-1:0] head_priority,
    output logic                       is_empty,
    output logic [pwq_pkg::COUNT_W-1:0] entry_count
);
    import pwq_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INS   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_HEAD  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              cmd_reg, cmd_next;
    logic [NAME_W-1:0] name_reg, name_next;
    logic [PRIO_W-1:0] pr_reg, pr_next;
    logic              ok_work_reg, ok_work_next;
    entry_t            removed_reg, removed_next;

    logic              out_valid_reg, out_valid_next;
    logic              ok_reg;
    entry_t            removed_out_reg;
    entry_t            head_reg;
    logic              empty_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic              load_out;

    logic              accept;
    logic              we, re;
    logic [CNT_W-1:0]  waddr_full, raddr_full;
    entry_t            wdata;
    entry_t            rdata;
    logic [$bits(entry_t)-1:0] rdata_bits;
    match_req_t        mreq;
    logic              hit;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    pwq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_full[IDX_W-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr_full[IDX_W-1:0]),
        .rdata (rdata_bits)
    );

    assign rdata = entry_t'(rdata_bits);

    pwq_match u_match (
        .req (mreq),
        .hit (hit)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        mreq.prio = rdata.prio;
        mreq.key  = pr_reg;
        if (cmd_reg == CMD_INSERT)
        begin
            mreq.mode = MATCH_GE;
        end
        else if (pr_reg == CLASS_LOW)
        begin
            mreq.mode = MATCH_LOW;
        end
        else
        begin
            mreq.mode = MATCH_NOT_ONE;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        cmd_next     = cmd_reg;
        name_next    = name_reg;
        pr_next      = pr_reg;
        ok_work_next = ok_work_reg;
        removed_next = removed_reg;
        we           = 1'b0;
        waddr_full   = k_reg;
        wdata        = rdata;
        re           = 1'b0;
        raddr_full   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                re         = accept;
                raddr_full = (cmd == CMD_INSERT) ? (count_reg - ONE_CNT) : '0;
                if (accept)
                begin
                    cmd_next     = cmd;
                    name_next    = name_code;
                    pr_next      = priority_req;
                    ok_work_next = 1'b0;
                    removed_next = '0;
                    k_next       = '0;
                    if (cmd == CMD_INSERT)
                    begin
                        k_next     = count_reg;
                        state_next = (count_reg >= CAP_CNT) ? ST_HEAD : ST_INS;
                    end
                    else if (count_reg == '0 ||
                             (priority_req != CLASS_LOW && priority_req != CLASS_OTHER))
                    begin
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_INS:
            begin
                // walk down from the tail; rdata holds entry k-1
                we         = 1'b1;
                waddr_full = k_reg;
                re         = 1'b1;
                raddr_full = k_reg - TWO_CNT;
                if (k_reg == '0 || hit)
                begin
                    wdata.name   = name_reg;
                    wdata.prio   = pr_reg;
                    count_next   = count_reg + ONE_CNT;
                    ok_work_next = 1'b1;
                    state_next   = ST_HEAD;
                end
                else
                begin
                    k_next = k_reg - ONE_CNT;
                end
            end

            ST_SCAN:
            begin
                // rdata holds entry k; read k+1 ahead
                re         = 1'b1;
                raddr_full = k_reg + ONE_CNT;
                if (hit)
                begin
                    removed_next = rdata;
                    ok_work_next = 1'b1;
                    if (k_reg + ONE_CNT >= count_reg)
                    begin
                        count_next = count_reg - ONE_CNT;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (k_reg + ONE_CNT >= count_reg)
                begin
                    state_next = ST_HEAD;
                end
                else
                begin
                    k_next = k_reg + ONE_CNT;
                end
            end

            ST_SHIFT:
            begin
                // rdata holds entry k+1; move it up into k
                we         = 1'b1;
                waddr_full = k_reg;
                re         = 1'b1;
                raddr_full = k_reg + TWO_CNT;
                k_next     = k_reg + ONE_CNT;
                if (k_reg + TWO_CNT >= count_reg)
                begin
                    count_next = count_reg - ONE_CNT;
                    state_next = ST_HEAD;
                end
            end

            ST_HEAD:
            begin
                re         = 1'b1;
                raddr_full = '0;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                // hold rdata until the result register frees up
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        cmd_reg     <= cmd_next;
        name_reg    <= name_next;
        pr_reg      <= pr_next;
        ok_work_reg <= ok_work_next;
        removed_reg <= removed_next;
        if (load_out)
        begin
            ok_reg          <= ok_work_reg;
            removed_out_reg <= removed_reg;
            head_reg        <= (count_reg != '0) ? rdata : '0;
            empty_reg       <= (count_reg == '0);
            count_out_reg   <= count_reg;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, count_out_reg};

    assign out_valid        = out_valid_reg;
    assign ok               = ok_reg;
    assign removed_name     = removed_out_reg.name;
    assign removed_priority = removed_out_reg.prio;
    assign head_name        = head_reg.name;
    assign head_priority    = head_reg.prio;
    assign is_empty         = empty_reg;
    assign entry_count      = count_ext[COUNT_W-1:0];

`include "priority_wait_queue_class_removal_unit_assert.svh"

    `PWQ_ASSERT(a_count_bound, count_reg <= CAP_CNT, "stored count exceeds capacity")
    `PWQ_ASSERT(a_ins_index, state_reg != ST_INS || k_reg <= count_reg, "bad insert index")
    `PWQ_ASSERT(a_shift_index, state_reg != ST_SHIFT || k_reg + ONE_CNT < count_reg, "bad shift index")
    `PWQ_ASSERT(a_empty_flag, !out_valid_reg || empty_reg == (count_out_reg == '0), "bad empty flag")
    `PWQ_ASSERT_NEXT(a_load_exits, load_out, state_reg == ST_IDLE && out_valid_reg, "stuck after load")

endmodule
